// ===== rtl/core/fir_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_pkg
// Shared constants for the loadable-tap FIR filter: field widths of the
// transaction payloads and the function codes of an input transaction.
// ----------------------------------------------------------------------------
package fir_pkg;

    localparam int IDX_BITS = 7;
    localparam int OUT_BITS = 40;

    typedef logic t_func;

    localparam t_func FUNC_LOAD   = 1'b0;
    localparam t_func FUNC_SAMPLE = 1'b1;

endpackage

// ===== rtl/core/fir_in_if.sv =====
// ----------------------------------------------------------------------------
// fir_in_if
// Input channel of the FIR filter: coefficient loads and samples share one
// valid/ready channel and are told apart by the function field.
// ----------------------------------------------------------------------------
interface fir_in_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
);
    logic                            valid;
    logic                            ready;
    fir_pkg::t_func                  func;
    logic [fir_pkg::IDX_BITS-1:0]    coef_index;
    logic signed [COEF_BITS-1:0]     coef_value;
    logic signed [SAMPLE_BITS-1:0]   sample_in;

    modport source (
        output valid, func, coef_index, coef_value, sample_in,
        input  ready
    );

    modport sink (
        input  valid, func, coef_index, coef_value, sample_in,
        output ready
    );
endinterface

// ===== rtl/core/fir_out_if.sv =====
// ----------------------------------------------------------------------------
// fir_out_if
// Output channel of the FIR filter: one full-precision result per sample.
// ----------------------------------------------------------------------------
interface fir_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fir_pkg::OUT_BITS-1:0] filtered;

    modport source (
        output valid, filtered,
        input  ready
    );

    modport sink (
        input  valid, filtered,
        output ready
    );
endinterface

// ===== rtl/core/fir_filter_loadable_taps.sv =====
// ----------------------------------------------------------------------------
// fir_filter_loadable_taps
// A direct-form FIR filter of TAPS taps whose coefficients are loaded at run
// time. A load transaction (func = 0) writes one coefficient; a load whose
// index is TAPS or more is ignored. A sample transaction (func = 1) enters
// the circular sample history and starts one pass of a single
// multiply-accumulate unit that reads one coefficient and one history entry
// per cycle from two RAMs; no other transaction is taken until that pass,
// which also waits for a pending result to be taken, is done.
// The result is the exact sum of products, wrapped to 40 bits, and waits in
// an output register, so the next transaction is accepted while it is still
// pending. Both stores read as zero after reset through per-entry valid bits;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module fir_filter_loadable_taps #(
    parameter int TAPS        = 101,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fir_in_if.sink    i_in,
    fir_out_if.source o_out
);

    localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PW   = SAMPLE_BITS + COEF_BITS;
    localparam int OW   = fir_pkg::OUT_BITS;
    localparam int EW   = (PW > OW) ? PW : OW;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_slot, n_slot;
    logic [TAPS-1:0] r_cvld, r_hvld;
    logic          r_rd_v, r_cv, r_hv;
    logic          r_prod_v;
    logic signed [PW-1:0] r_prod;
    logic [OW-1:0] r_acc;
    logic          r_out_v;
    logic [OW-1:0] r_out;

    logic in_acc, ld_ok, smp_acc, out_free, done;
    logic [AW-1:0] ld_addr;
    logic [COEF_BITS-1:0]   coef_rd;
    logic [SAMPLE_BITS-1:0] hist_rd;
    logic signed [COEF_BITS-1:0]   op_c;
    logic signed [SAMPLE_BITS-1:0] op_s;
    logic signed [EW-1:0] prod_ext;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign ld_ok      = in_acc && (i_in.func == fir_pkg::FUNC_LOAD)
                        && (int'(i_in.coef_index) < TAPS);
    assign smp_acc    = in_acc && (i_in.func == fir_pkg::FUNC_SAMPLE);
    assign ld_addr    = AW'(i_in.coef_index);
    assign out_free   = !r_out_v || o_out.ready;
    assign done       = (r_state == S_DRAIN) && !r_rd_v && !r_prod_v && out_free;

    fir_ram #(.WIDTH(COEF_BITS), .DEPTH(TAPS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ld_ok),
        .i_waddr (ld_addr),
        .i_wdata (i_in.coef_value),
        .i_raddr (r_cnt),
        .o_rdata (coef_rd)
    );

    fir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAPS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (smp_acc),
        .i_waddr (r_ptr),
        .i_wdata (i_in.sample_in),
        .i_raddr (r_slot),
        .o_rdata (hist_rd)
    );

    // Sequencer: walk tap k upward while the history slot walks backward.
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_cnt   = r_cnt;
        n_slot  = r_slot;
        unique case (r_state)
            S_IDLE: begin
                if (smp_acc) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                    n_slot  = r_ptr;
                    n_ptr   = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;
                end
            end
            S_RUN: begin
                if (r_cnt == LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt  = r_cnt + 1'b1;
                    n_slot = (r_slot == '0) ? LAST : r_slot - 1'b1;
                end
            end
            S_DRAIN: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Entries never written read as zero.
    assign op_c     = r_cv ? signed'(coef_rd) : '0;
    assign op_s     = r_hv ? signed'(hist_rd) : '0;
    assign prod_ext = EW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_cnt    <= '0;
            r_slot   <= '0;
            r_cvld   <= '0;
            r_hvld   <= '0;
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_cnt    <= n_cnt;
            r_slot   <= n_slot;
            r_rd_v   <= (r_state == S_RUN);
            r_prod_v <= r_rd_v;
            if (ld_ok) begin
                r_cvld[ld_addr] <= 1'b1;
            end
            if (smp_acc) begin
                r_hvld[r_ptr] <= 1'b1;
            end
            if (done) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cv   <= r_cvld[r_cnt];
        r_hv   <= r_hvld[r_slot];
        r_prod <= op_c * op_s;
        if (smp_acc) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + prod_ext[OW-1:0];
        end
        if (done) begin
            r_out <= r_acc;
        end
    end

    assign o_out.valid    = r_out_v;
    assign o_out.filtered = signed'(r_out);

    a_accept_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_state == S_IDLE))
        else $error("transaction accepted while a sample is in progress");

    a_acc_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        smp_acc |=> (r_acc == '0) && (r_state == S_RUN))
        else $error("accumulator not cleared at the start of a sample");

    a_out_from_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == S_DRAIN))
        else $error("result presented outside the end of a sample pass");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (!r_out_v || o_out.ready))
        else $error("pending result overwritten");

    a_pipe_empty_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_rd_v && !r_prod_v))
        else $error("multiply pipeline busy while idle");

endmodule

// ===== rtl/core/fir_ram.sv =====
// ----------------------------------------------------------------------------
// fir_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No reset on the storage.
// ----------------------------------------------------------------------------
module fir_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 101,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
